FILE: rtl/fcl_pkg.sv
`default_nettype none

package fcl_pkg;

    localparam int DEF_SLOTS = 32;
    localparam int KEY_W     = 32;
    localparam int BYTES_W   = 16;
    localparam int HITS_W    = 16;
    localparam int LOG_W     = 40;
    localparam int THR_W     = 16;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 1;
    localparam int FUNC_W    = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT      = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FIND        = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READMIT     = 2'd2;
    localparam logic [FUNC_W-1:0] FN_INSERT_SETS = 2'd3;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_RES  = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic [LOG_W-1:0]  CAP_RESET = 40'd1048576;
    localparam logic [THR_W-1:0]  THR_RESET = 16'd0;
    localparam logic [HITS_W-1:0] HITS_MAX  = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FL_RD,
        S_FL_EV,
        S_STORE,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
        logic [HITS_W-1:0]  hits;
    } t_slot;

    typedef struct packed {
        logic [LOG_W-1:0] cap;
        logic [THR_W-1:0] thr;
    } t_cfg;

    typedef struct packed {
        logic               found;
        logic               accepted;
        logic               evict_valid;
        logic [KEY_W-1:0]   evict_key;
        logic [BYTES_W-1:0] evict_bytes;
        logic [LOG_W-1:0]   used_bytes;
        logic               last;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/flush_on_full_log_cache.sv
// A request is taken only while the block is idle, so a new request waits until the previous
// one has finished its slot memory sweep and handed over its result beats.
// A flush inserts a second sweep over all slots, held back by output stalls; its store state
// takes the place of the final state unless no entry was resident.
// Both sweeps go through the single read port of the slot memory.
// Reset (synchronous, i_rst_n low): all slots free, byte count zero, capacity 1048576,
// readmit threshold zero; slot memory contents are not cleared.
`default_nettype none

module flush_on_full_log_cache import fcl_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,   // item_key, item_bytes
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,   // func
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [95:0]               m_axis_tdata,   // found, accepted, evict_key,
                                                      // evict_bytes, used_bytes
    output logic                      m_axis_tuser,   // evict_valid
    output logic                      m_axis_tlast
);

    t_cfg r_cfg;
    logic r_out_vld;
    t_res r_out;
    logic res_push;
    t_res res;
    logic res_ready;

    assign res_ready = !r_out_vld || m_axis_tready;

    fcl_seq #(
        .SLOTS(SLOTS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_key      (s_axis_tdata[31:0]),
        .i_bytes    (s_axis_tdata[47:32]),
        .i_cfg      (r_cfg),
        .o_res_push (res_push),
        .o_res      (res),
        .i_res_ready(res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cap <= CAP_RESET;
            r_cfg.thr <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CAPACITY:  r_cfg.cap <= i_cfg_wdata[LOG_W-1:0];
                CFG_THRESHOLD: r_cfg.thr <= i_cfg_wdata[THR_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // hold the result beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_push) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.used_bytes, r_out.evict_bytes, r_out.evict_key,
                            r_out.accepted, r_out.found};
    assign m_axis_tuser  = r_out.evict_valid;
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

FILE: rtl/fcl_ram.sv
`default_nettype none

module fcl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fcl_seq.sv
`default_nettype none

module fcl_seq import fcl_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [KEY_W-1:0]   i_key,
    input  wire logic [BYTES_W-1:0] i_bytes,
    input  wire t_cfg               i_cfg,
    output logic                    o_res_push,
    output t_res                    o_res,
    input  wire logic               i_res_ready
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    t_state r_state, n_state;

    logic [FUNC_W-1:0]  r_func, n_func;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [IW-1:0]      r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [IW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_r_hit, n_r_hit;
    logic [IW-1:0]      r_r_idx, n_r_idx;
    logic [BYTES_W-1:0] r_r_bytes, n_r_bytes;
    logic [HITS_W-1:0]  r_r_hits, n_r_hits;
    logic               r_p_hit, n_p_hit;
    logic [IW-1:0]      r_p_idx, n_p_idx;
    logic [HITS_W-1:0]  r_p_hits, n_p_hits;
    logic               r_f_hit, n_f_hit;
    logic [IW-1:0]      r_f_idx, n_f_idx;
    logic               r_any_res, n_any_res;
    logic [IW-1:0]      r_last_res, n_last_res;
    logic               r_nf_hit, n_nf_hit;
    logic [IW-1:0]      r_nf_idx, n_nf_idx;
    logic               r_np_hit, n_np_hit;
    logic [IW-1:0]      r_np_idx, n_np_idx;
    logic [LOG_W-1:0]   r_log, n_log;
    logic               r_found, n_found;
    logic               r_acc, n_acc;
    logic [1:0]         r_status [SLOTS];

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_slot             ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [$bits(t_slot)-1:0] ram_rdata;
    t_slot             ram_q;

    logic              st_we;
    logic [IW-1:0]     st_waddr;
    logic [1:0]        st_wdata;
    logic [IW-1:0]     st_ridx;
    logic [1:0]        rd_status;

    logic [LOG_W:0]    sum;
    logic              fit_le;
    logic              fit_lt;
    logic              do_flush;
    logic              thr_on;

    logic              dec_ram_we;
    logic [IW-1:0]     dec_ram_addr;
    t_slot             dec_ram_data;
    logic              dec_st_we;
    logic [IW-1:0]     dec_st_addr;
    logic [1:0]        dec_st_data;
    logic              dec_add;
    logic              dec_found;
    logic              dec_acc;

    logic              ev_res;
    logic [1:0]        ev_ns;
    logic              ev_go;
    logic [IW-1:0]     store_idx;

    fcl_ram #(
        .WIDTH($bits(t_slot)),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign ram_q     = t_slot'(ram_rdata);
    assign st_ridx   = (r_state == S_FL_EV) ? r_idx : r_rd_idx;
    assign rd_status = r_status[st_ridx];
    assign thr_on    = (i_cfg.thr != '0);

    assign sum      = {1'b0, r_log} + (LOG_W + 1)'(r_bytes);
    assign fit_le   = (sum <= {1'b0, i_cfg.cap});
    assign fit_lt   = (sum <  {1'b0, i_cfg.cap});
    assign do_flush = (r_func == FN_INSERT) && (!fit_le || (!r_r_hit && !r_f_hit));

    assign ev_res = (rd_status == ST_RES);
    assign ev_go  = !ev_res || i_res_ready;
    always_comb begin
        if (ev_res) begin
            ev_ns = thr_on ? ST_PEND : ST_FREE;
        end else if (rd_status == ST_PEND) begin
            ev_ns = ST_FREE;
        end else begin
            ev_ns = rd_status;
        end
    end

    always_comb begin
        if (r_nf_hit) begin
            store_idx = r_nf_idx;
        end else if (r_np_hit) begin
            store_idx = r_np_idx;
        end else begin
            store_idx = '0;
        end
    end

    always_comb begin
        dec_ram_we   = 1'b0;
        dec_ram_addr = r_r_idx;
        dec_ram_data = '{key: r_key, bytes: r_r_bytes, hits: '0};
        dec_st_we    = 1'b0;
        dec_st_addr  = r_p_idx;
        dec_st_data  = ST_FREE;
        dec_add      = 1'b0;
        dec_found    = 1'b0;
        dec_acc      = 1'b0;
        case (r_func)
            FN_INSERT: begin
                dec_acc = 1'b1;
                dec_add = 1'b1;
                dec_ram_we = 1'b1;
                if (!r_r_hit) begin
                    dec_ram_addr = r_f_idx;
                    dec_ram_data = '{key: r_key, bytes: r_bytes, hits: '0};
                    dec_st_we    = 1'b1;
                    dec_st_addr  = r_f_idx;
                    dec_st_data  = ST_RES;
                end
            end
            FN_FIND: begin
                if (r_r_hit) begin
                    dec_found  = 1'b1;
                    dec_ram_we = 1'b1;
                    dec_ram_data.hits = (r_r_hits == HITS_MAX) ? r_r_hits
                                                               : r_r_hits + 16'd1;
                end
            end
            FN_READMIT: begin
                if (thr_on && r_p_hit) begin
                    dec_st_we = 1'b1;
                    if ((r_p_hits > i_cfg.thr) && fit_lt) begin
                        dec_acc    = 1'b1;
                        dec_add    = 1'b1;
                        dec_ram_we = 1'b1;
                        if (!r_r_hit) begin
                            dec_ram_addr = r_p_idx;
                            dec_ram_data = '{key: r_key, bytes: r_bytes, hits: '0};
                            dec_st_data  = ST_RES;
                        end
                    end
                end
            end
            FN_INSERT_SETS: begin
                if (fit_le && (r_r_hit || r_f_hit)) begin
                    dec_acc    = 1'b1;
                    dec_add    = 1'b1;
                    dec_ram_we = 1'b1;
                    if (!r_r_hit) begin
                        dec_ram_addr = r_f_idx;
                        dec_ram_data = '{key: r_key, bytes: r_bytes, hits: '0};
                        dec_st_we    = 1'b1;
                        dec_st_addr  = r_f_idx;
                        dec_st_data  = ST_RES;
                    end
                end
            end
            default: begin
                dec_acc = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_vld && (r_rd_idx == LAST)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = do_flush ? S_FL_RD : S_FINAL;
            end
            S_FL_RD: begin
                n_state = S_FL_EV;
            end
            S_FL_EV: begin
                if (ev_go) begin
                    n_state = (r_idx == LAST) ? S_STORE : S_FL_RD;
                end
            end
            S_STORE: begin
                n_state = r_any_res ? S_IDLE : S_FINAL;
            end
            S_FINAL: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        ram_we     = 1'b0;
        ram_waddr  = dec_ram_addr;
        ram_wdata  = dec_ram_data;
        ram_re     = 1'b0;
        ram_raddr  = r_idx;
        st_we      = 1'b0;
        st_waddr   = r_idx;
        st_wdata   = ev_ns;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SCAN: begin
                ram_re = 1'b1;
            end
            S_DECIDE: begin
                if (!do_flush) begin
                    ram_we   = dec_ram_we;
                    st_we    = dec_st_we;
                    st_waddr = dec_st_addr;
                    st_wdata = dec_st_data;
                end
            end
            S_FL_RD: begin
                ram_re = 1'b1;
            end
            S_FL_EV: begin
                st_we                = ev_go;
                o_res_push           = ev_res && i_res_ready;
                o_res.evict_valid    = 1'b1;
                o_res.evict_key      = ram_q.key;
                o_res.evict_bytes    = ram_q.bytes;
                o_res.used_bytes     = LOG_W'(r_bytes);
                o_res.last           = (r_idx == r_last_res);
                o_res.accepted       = (r_idx == r_last_res);
            end
            S_STORE: begin
                ram_we    = 1'b1;
                ram_waddr = store_idx;
                ram_wdata = '{key: r_key, bytes: r_bytes, hits: '0};
                st_we     = 1'b1;
                st_waddr  = store_idx;
                st_wdata  = ST_RES;
            end
            S_FINAL: begin
                o_res_push       = i_res_ready;
                o_res.found      = r_found;
                o_res.accepted   = r_acc;
                o_res.used_bytes = r_log;
                o_res.last       = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_func     = r_func;
        n_key      = r_key;
        n_bytes    = r_bytes;
        n_idx      = r_idx;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_r_hit    = r_r_hit;
        n_r_idx    = r_r_idx;
        n_r_bytes  = r_r_bytes;
        n_r_hits   = r_r_hits;
        n_p_hit    = r_p_hit;
        n_p_idx    = r_p_idx;
        n_p_hits   = r_p_hits;
        n_f_hit    = r_f_hit;
        n_f_idx    = r_f_idx;
        n_any_res  = r_any_res;
        n_last_res = r_last_res;
        n_nf_hit   = r_nf_hit;
        n_nf_idx   = r_nf_idx;
        n_np_hit   = r_np_hit;
        n_np_idx   = r_np_idx;
        n_log      = r_log;
        n_found    = r_found;
        n_acc      = r_acc;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func    = i_func;
                    n_key     = i_key;
                    n_bytes   = i_bytes;
                    n_idx     = '0;
                    n_rd_vld  = 1'b0;
                    n_r_hit   = 1'b0;
                    n_p_hit   = 1'b0;
                    n_f_hit   = 1'b0;
                    n_any_res = 1'b0;
                end
            end
            S_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                if (r_idx != LAST) begin
                    n_idx = r_idx + IW'(1);
                end
                if (r_rd_vld) begin
                    if (rd_status == ST_RES) begin
                        n_any_res  = 1'b1;
                        n_last_res = r_rd_idx;
                        if (!r_r_hit && (ram_q.key == r_key)) begin
                            n_r_hit   = 1'b1;
                            n_r_idx   = r_rd_idx;
                            n_r_bytes = ram_q.bytes;
                            n_r_hits  = ram_q.hits;
                        end
                    end
                    if ((rd_status == ST_PEND) && !r_p_hit && (ram_q.key == r_key)) begin
                        n_p_hit  = 1'b1;
                        n_p_idx  = r_rd_idx;
                        n_p_hits = ram_q.hits;
                    end
                    if ((rd_status == ST_FREE) && !r_f_hit) begin
                        n_f_hit = 1'b1;
                        n_f_idx = r_rd_idx;
                    end
                end
            end
            S_DECIDE: begin
                if (do_flush) begin
                    n_idx    = '0;
                    n_nf_hit = 1'b0;
                    n_np_hit = 1'b0;
                end else begin
                    n_found = dec_found;
                    n_acc   = dec_acc;
                    if (dec_add) begin
                        n_log = sum[LOG_W-1:0];
                    end
                end
            end
            S_FL_EV: begin
                if (ev_go) begin
                    if ((ev_ns == ST_FREE) && !r_nf_hit) begin
                        n_nf_hit = 1'b1;
                        n_nf_idx = r_idx;
                    end
                    if ((ev_ns == ST_PEND) && !r_np_hit) begin
                        n_np_hit = 1'b1;
                        n_np_idx = r_idx;
                    end
                    if (r_idx != LAST) begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_STORE: begin
                n_log   = LOG_W'(r_bytes);
                n_found = 1'b0;
                n_acc   = 1'b1;
            end
            default: begin
                n_log = r_log;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_log    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_FREE;
            end
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_log    <= n_log;
            if (st_we) begin
                r_status[st_waddr] <= st_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_bytes    <= n_bytes;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_r_hit    <= n_r_hit;
        r_r_idx    <= n_r_idx;
        r_r_bytes  <= n_r_bytes;
        r_r_hits   <= n_r_hits;
        r_p_hit    <= n_p_hit;
        r_p_idx    <= n_p_idx;
        r_p_hits   <= n_p_hits;
        r_f_hit    <= n_f_hit;
        r_f_idx    <= n_f_idx;
        r_any_res  <= n_any_res;
        r_last_res <= n_last_res;
        r_nf_hit   <= n_nf_hit;
        r_nf_idx   <= n_nf_idx;
        r_np_hit   <= n_np_hit;
        r_np_idx   <= n_np_idx;
        r_found    <= n_found;
        r_acc      <= n_acc;
    end

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> i_res_ready)
        else $error("result beat pushed while output stage full");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_SCAN && !r_rd_vld))
        else $error("accepted beat did not start a clean scan");

    a_evict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.evict_valid) |->
            (r_state == S_FL_EV && o_res.used_bytes == LOG_W'(r_bytes)))
        else $error("eviction beat outside flush sweep or with wrong byte count");

    a_store_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |=> (r_log == LOG_W'($past(r_bytes))))
        else $error("byte count not restarted after flush");

endmodule

`default_nettype wire

FILE: tb/tb_flush_on_full_log_cache.sv
`timescale 1ns / 100ps

module tb_flush_on_full_log_cache;
    import fcl_pkg::*;

    class flush_log_checker;
        logic [LOG_W-1:0]   cap;
        logic [THR_W-1:0]   thr;
        logic [LOG_W-1:0]   used;
        logic [KEY_W-1:0]   key_mem  [DEF_SLOTS];
        logic [BYTES_W-1:0] size_mem [DEF_SLOTS];
        logic [HITS_W-1:0]  hit_mem  [DEF_SLOTS];
        logic [1:0]         status   [DEF_SLOTS];
        t_res               due_results [$];
        int                 errors;
        int                 beats;
        int                 requests;
        int                 flushes;
        int                 stores;

        function new();
            cap = CAP_RESET;
            thr = THR_RESET;
            used = '0;
            foreach (status[i]) status[i] = ST_FREE;
            errors = 0;
            beats = 0;
            requests = 0;
            flushes = 0;
            stores = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_CAPACITY)
                cap = val[LOG_W-1:0];
            else
                thr = val[THR_W-1:0];
        endfunction

        function int slot_with(logic [1:0] st, logic [KEY_W-1:0] k);
            for (int i = 0; i < DEF_SLOTS; i++)
                if (status[i] == st && key_mem[i] == k)
                    return i;
            return -1;
        endfunction

        function int first_of(logic [1:0] st);
            for (int i = 0; i < DEF_SLOTS; i++)
                if (status[i] == st)
                    return i;
            return -1;
        endfunction

        function void place(int s, logic [KEY_W-1:0] k, logic [BYTES_W-1:0] b);
            key_mem[s] = k;
            size_mem[s] = b;
            hit_mem[s] = '0;
            status[s] = ST_RES;
            used = used + LOG_W'(b);
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k,
                                   logic [BYTES_W-1:0] b);
            t_res           step_out [$];
            t_res           r;
            logic [LOG_W:0] grown;
            int             hit;
            int             s;
            int             n;
            logic           fnd;
            logic           acc;
            fnd = 1'b0;
            acc = 1'b0;
            grown = {1'b0, used} + (LOG_W + 1)'(b);
            requests++;
            case (fn)
                FN_INSERT: begin
                    hit = slot_with(ST_RES, k);
                    if (grown > {1'b0, cap} || (hit < 0 && first_of(ST_FREE) < 0)) begin
                        flushes++;
                        for (int i = 0; i < DEF_SLOTS; i++)
                            if (status[i] == ST_PEND)
                                status[i] = ST_FREE;
                        for (int i = 0; i < DEF_SLOTS; i++) begin
                            if (status[i] == ST_RES) begin
                                r = '0;
                                r.evict_valid = 1'b1;
                                r.evict_key = key_mem[i];
                                r.evict_bytes = size_mem[i];
                                step_out.push_back(r);
                                status[i] = (thr != '0) ? ST_PEND : ST_FREE;
                            end
                        end
                        used = '0;
                        hit = -1;
                    end
                    if (hit >= 0) begin
                        used = used + LOG_W'(b);
                        hit_mem[hit] = '0;
                    end else begin
                        s = first_of(ST_FREE);
                        if (s < 0)
                            s = first_of(ST_PEND);
                        if (s < 0)
                            s = 0;
                        place(s, k, b);
                    end
                    acc = 1'b1;
                end
                FN_FIND: begin
                    hit = slot_with(ST_RES, k);
                    if (hit >= 0) begin
                        fnd = 1'b1;
                        if (hit_mem[hit] != HITS_MAX)
                            hit_mem[hit] = hit_mem[hit] + HITS_W'(1);
                    end
                end
                FN_READMIT: begin
                    s = (thr != '0) ? slot_with(ST_PEND, k) : -1;
                    if (s >= 0) begin
                        if (hit_mem[s] > thr && grown < {1'b0, cap}) begin
                            hit = slot_with(ST_RES, k);
                            if (hit >= 0) begin
                                used = used + LOG_W'(b);
                                hit_mem[hit] = '0;
                                status[s] = ST_FREE;
                            end else begin
                                place(s, k, b);
                            end
                            acc = 1'b1;
                        end else begin
                            status[s] = ST_FREE;
                        end
                    end
                end
                FN_INSERT_SETS: begin
                    if (grown <= {1'b0, cap}) begin
                        hit = slot_with(ST_RES, k);
                        if (hit >= 0) begin
                            used = used + LOG_W'(b);
                            hit_mem[hit] = '0;
                            acc = 1'b1;
                        end else begin
                            s = first_of(ST_FREE);
                            if (s >= 0) begin
                                place(s, k, b);
                                acc = 1'b1;
                            end
                        end
                    end
                end
            endcase
            if (step_out.size() == 0) begin
                r = '0;
                step_out.push_back(r);
            end
            n = step_out.size() - 1;
            foreach (step_out[i]) step_out[i].used_bytes = used;
            step_out[n].found = fnd;
            step_out[n].accepted = acc;
            step_out[n].last = 1'b1;
            if (acc)
                stores++;
            foreach (step_out[i]) due_results.push_back(step_out[i]);
        endfunction

        function void check_result(t_res got);
            t_res want;
            beats++;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: key %h bytes %0d used %0d last %b",
                             got.evict_key, got.evict_bytes, got.used_bytes, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.found !== want.found || got.accepted !== want.accepted ||
                got.evict_valid !== want.evict_valid || got.evict_key !== want.evict_key ||
                got.evict_bytes !== want.evict_bytes || got.used_bytes !== want.used_bytes ||
                got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at beat %0d", beats);
                    $display("  expected found %b acc %b ev %b key %h bytes %0d used %0d last %b",
                             want.found, want.accepted, want.evict_valid, want.evict_key,
                             want.evict_bytes, want.used_bytes, want.last);
                    $display("  actual   found %b acc %b ev %b key %h bytes %0d used %0d last %b",
                             got.found, got.accepted, got.evict_valid, got.evict_key,
                             got.evict_bytes, got.used_bytes, got.last);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata;   // item_key, item_bytes
    logic [FUNC_W-1:0]    s_axis_tuser;   // func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [95:0]          m_axis_tdata;   // found, accepted, evict_key, evict_bytes, used_bytes
    logic                 m_axis_tuser;   // evict_valid
    logic                 m_axis_tlast;

    flush_log_checker sb = new();
    int               rx_hold;
    bit               steady;
    int               fresh;

    always #4 i_clk = ~i_clk;

    flush_on_full_log_cache #(.SLOTS(DEF_SLOTS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    task automatic set_config(input logic [LOG_W-1:0] cap, input logic [THR_W-1:0] thr);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_CAPACITY;
        i_cfg_wdata <= CFG_W'(cap);
        @(posedge i_clk);
        sb.set_register(CFG_CAPACITY, CFG_W'(cap));
        i_cfg_addr <= CFG_THRESHOLD;
        i_cfg_wdata <= CFG_W'(thr);
        @(posedge i_clk);
        sb.set_register(CFG_THRESHOLD, CFG_W'(thr));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k,
                             input logic [BYTES_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, k};
        s_axis_tuser <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(fn, k, b);
    endtask

    // hold off new work until every predicted beat has arrived and the block settles
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (DEF_SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [LOG_W-1:0] cap, input logic [THR_W-1:0] thr,
                             input int pool, input int count, input int bmax);
        logic [KEY_W-1:0]  base;
        logic [KEY_W-1:0]  k;
        logic [FUNC_W-1:0] fn;
        int                pick;
        int                back;
        base = $urandom();
        drain_results();
        set_config(cap, thr);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pool == 0)
                fn = (pick < 72) ? FN_INSERT : (pick < 82) ? FN_FIND :
                     (pick < 94) ? FN_READMIT : FN_INSERT_SETS;
            else
                fn = (pick < 35) ? FN_INSERT : (pick < 65) ? FN_FIND :
                     (pick < 85) ? FN_READMIT : FN_INSERT_SETS;
            if ($urandom_range(0, 19) == 0) begin
                k = $urandom();
            end else if (pool == 0 && fn == FN_INSERT) begin
                k = {base[31:16], fresh[15:0]};
                fresh++;
            end else if (pool == 0) begin
                back = fresh - 1 - $urandom_range(0, 39);
                k = {base[31:16], back[15:0]};
            end else begin
                k = base + $urandom_range(0, pool - 1);
            end
            send_item(fn, k, BYTES_W'($urandom_range(0, bmax)));
        end
    endtask

    initial begin : result_sink
        int   stall;
        t_res got;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tdata[0];
                got.accepted = m_axis_tdata[1];
                got.evict_key = m_axis_tdata[33:2];
                got.evict_bytes = m_axis_tdata[49:34];
                got.used_bytes = m_axis_tdata[89:50];
                got.evict_valid = m_axis_tuser;
                got.last = m_axis_tlast;
                sb.check_result(got);
                stall = steady ? 0 : $urandom_range(0, 17);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_CAPACITY;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FN_INSERT;
        rx_hold = 0;
        steady = 1'b0;
        fresh = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(40'd1000, 16'd2);
        send_item(FN_FIND, 32'h0000_0000, 16'd0);
        send_item(FN_INSERT, 32'h0000_0000, 16'd100);
        send_item(FN_INSERT, 32'hFFFF_FFFF, 16'd0);
        repeat (3) send_item(FN_FIND, 32'h0000_0000, 16'd0);
        send_item(FN_FIND, 32'hFFFF_FFFF, 16'hFFFF);
        // duplicate resident key: bytes add up, hits restart
        send_item(FN_INSERT, 32'h0000_0000, 16'd50);
        repeat (3) send_item(FN_FIND, 32'h0000_0000, 16'd0);
        send_item(FN_INSERT_SETS, 32'h0000_0005, 16'd900);
        send_item(FN_INSERT_SETS, 32'h0000_0005, 16'd850);
        // over budget: flush everything to pending
        send_item(FN_INSERT, 32'h0000_0007, 16'd1);
        send_item(FN_INSERT, 32'h0000_0000, 16'd20);
        send_item(FN_READMIT, 32'h0000_0000, 16'd30);
        send_item(FN_READMIT, 32'hFFFF_FFFF, 16'd10);
        send_item(FN_READMIT, 32'h0000_1234, 16'd5);
        // oversized object still lands after the flush
        send_item(FN_INSERT, 32'h8000_0001, 16'hFFFF);
        send_item(FN_INSERT_SETS, 32'h0000_0009, 16'd0);
        send_item(FN_READMIT, 32'h0000_0007, 16'd0);
        send_item(FN_FIND, 32'h8000_0001, 16'd0);

        drain_results();
        set_config(40'd0, 16'd0);
        send_item(FN_INSERT, 32'h0000_0003, 16'd0);
        send_item(FN_READMIT, 32'h0000_0003, 16'd0);
        send_item(FN_INSERT_SETS, 32'h0000_0004, 16'd0);

        run_phase(40'd4000, 16'd1, 12, 40, 1200);
        // distinct keys exhaust the slots and force full-width flushes
        run_phase(40'hFF_FFFF_FFFF, 16'd3, 0, 60, 65535);
        run_phase(40'd0, 16'hFFFF, 6, 25, 65535);
        steady = 1'b1;
        run_phase(40'd20000, 16'd2, 40, 45, 3000);
        steady = 1'b0;
        drain_results();
        rx_hold = 600;
        run_phase(40'd1048576, 16'd0, 16, 35, 200000 > 65535 ? 65535 : 0);
        run_phase(40'd300000, 16'd1, 20, 40, 65535);

        drain_results();
        sb.errors += sb.due_results.size();
        $display("run covered %0d requests and %0d result beats", sb.requests, sb.beats);
        $display("  including %0d flushes and %0d accepted stores", sb.flushes, sb.stores);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fcl_pkg.sv
rtl/fcl_ram.sv
rtl/fcl_seq.sv
rtl/flush_on_full_log_cache.sv
tb/tb_flush_on_full_log_cache.sv
